[sv/array_insert_delete_list_macros.svh]
// Assertion macros for the ordered-list RTL top level.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef ARRAY_INSERT_DELETE_LIST_MACROS_SVH
`define ARRAY_INSERT_DELETE_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AIDL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/aidl_pkg.sv]
// Shared types and constants for the ordered insert/delete list.
// No dependencies; used by aidl_cell and array_insert_delete_list.
package aidl_pkg;

    // Default number of list cells.
    localparam int DEF_LIST_DEPTH = 16;

    // Fixed field widths of the beats.
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int MIDX_W   = 4;
    localparam int COUNT_W  = 5;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic ins_go;   // accepted insert that passed its checks
        logic del_go;   // accepted delete (shifts only if a match exists)
    } cell_op_t;

endpackage

[sv/aidl_cell.sv]
// One list cell: holds an entry, compares it against the search value
// and shifts toward or away from its neighbors. Depends on aidl_pkg.
module aidl_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  logic                              clk,
    input  aidl_pkg::cell_op_t                op,
    input  logic [CNT_W-1:0]                  pos,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [aidl_pkg::VALUE_W-1:0] value,
    input  logic signed [aidl_pkg::VALUE_W-1:0] left_data,
    input  logic signed [aidl_pkg::VALUE_W-1:0] right_data,
    input  logic                              prefix_in,
    output logic                              hit,
    output logic                              prefix_out,
    output logic signed [aidl_pkg::VALUE_W-1:0] data_out
);
    import aidl_pkg::*;

    localparam logic [CNT_W-1:0] IDX_V  = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] NEXT_V = CNT_W'(CELL_IDX + 1);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    // Compare only live entries; the match chain marks every cell at or
    // after the first match.
    assign hit        = (IDX_V < count) && (data_reg == value);
    assign prefix_out = prefix_in | hit;
    assign data_out   = data_reg;

    // Shift selection for insert and delete.
    always_comb
    begin
        data_next = data_reg;
        if (op.ins_go)
        begin
            if (IDX_V == pos)
                data_next = value;
            else if ((IDX_V > pos) && (IDX_V <= count))
                data_next = left_data;
        end
        else if (op.del_go)
        begin
            if (prefix_out && (NEXT_V < count))
                data_next = right_data;
        end
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[sv/array_insert_delete_list.sv]
// Top level of the ordered insert/delete list built from a row of cells.
// Depends on aidl_pkg, aidl_cell and array_insert_delete_list_macros.svh.
//
// Usage:
// - Input channel (in_valid / in_stall) carries one operation per beat:
//   func selects insert at position, delete first match, or read position.
// - Output channel (out_valid / out_stall) returns one result beat per
//   operation: status, read_value, match_index and entry_count.
// - The result is registered: the result of a beat accepted at one edge is
//   shown from the next cycle on. Throughput is one beat per cycle while
//   out_stall is low; the cell row compares and shifts all entries together
//   through a ripple match chain.
// - Reset empties the list (count zero) and drops any pending result;
//   entry contents are not cleared and are never read before written.
// - When the receiver stalls, the result register holds its beat and
//   in_stall rises, so no new operation is taken until it drains.
`include "array_insert_delete_list_macros.svh"

module array_insert_delete_list #(
    parameter int LIST_DEPTH = aidl_pkg::DEF_LIST_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [aidl_pkg::FUNC_W-1:0]          func,
    input  logic [aidl_pkg::POS_W-1:0]           position,
    input  logic signed [aidl_pkg::VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [aidl_pkg::STATUS_W-1:0]        status,
    output logic signed [aidl_pkg::VALUE_W-1:0]  read_value,
    output logic [aidl_pkg::MIDX_W-1:0]          match_index,
    output logic [aidl_pkg::COUNT_W-1:0]         entry_count
);
    import aidl_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int MI_W  = (IDX_W > MIDX_W) ? IDX_W : MIDX_W;
    localparam logic [CNT_W-1:0] FULL_V = CNT_W'(LIST_DEPTH);

    logic                     take;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         cnt_w;
    logic [CMP_W-1:0]         cnt_next_w;
    logic                     is_full;
    logic                     ins_pos_ok;
    logic                     rd_pos_ok;
    logic                     found;
    logic [MI_W-1:0]          idx_w;
    cell_op_t                 op;
    func_t                    fcode;

    logic signed [VALUE_W-1:0] cell_q [LIST_DEPTH];
    logic                      hit_v  [LIST_DEPTH];
    logic                      prefix [LIST_DEPTH+1];

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic signed [VALUE_W-1:0] read_value_next;
    logic [MIDX_W-1:0]         match_index_reg;
    logic [MIDX_W-1:0]         match_index_next;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic [COUNT_W-1:0]        entry_count_next;

    // Handshake: take a beat whenever the result register is free or drains.
    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;
    assign fcode    = func_t'(func);

    // Range checks in a width that holds both the position and the count.
    assign pos_w      = CMP_W'(position);
    assign cnt_w      = CMP_W'(count_reg);
    assign is_full    = (count_reg == FULL_V);
    assign ins_pos_ok = (pos_w <= cnt_w);
    assign rd_pos_ok  = (pos_w < cnt_w);

    // Command for the cell row.
    assign op.ins_go = take && (fcode == FUNC_INSERT) && !is_full && ins_pos_ok;
    assign op.del_go = take && (fcode == FUNC_DELETE);

    // Row of cells with the first-match chain running from index 0 upward.
    assign prefix[0] = 1'b0;
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_d;
        logic signed [VALUE_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = value;
        end
        else
        begin : g_left
            assign left_d = cell_q[i-1];
        end
        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_d = cell_q[i];
        end
        else
        begin : g_right
            assign right_d = cell_q[i+1];
        end
        aidl_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .pos        (CNT_W'(pos_w)),
            .count      (count_reg),
            .value      (value),
            .left_data  (left_d),
            .right_data (right_d),
            .prefix_in  (prefix[i]),
            .hit        (hit_v[i]),
            .prefix_out (prefix[i+1]),
            .data_out   (cell_q[i])
        );
    end

    assign found = prefix[LIST_DEPTH];

    // Encode the index of the first match (one cell at most is first).
    always_comb
    begin
        idx_w = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (hit_v[i] && !prefix[i])
                idx_w = idx_w | MI_W'(i);
        end
    end

    // Count update.
    always_comb
    begin
        count_next = count_reg;
        if (op.ins_go)
            count_next = count_reg + CNT_W'(1);
        else if (op.del_go && found)
            count_next = count_reg - CNT_W'(1);
    end

    // Result fields for the accepted beat.
    always_comb
    begin
        status_next      = ST_OK;
        read_value_next  = '0;
        match_index_next = '0;
        cnt_next_w       = CMP_W'(count_next);
        entry_count_next = cnt_next_w[COUNT_W-1:0];
        case (fcode)
            FUNC_INSERT:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else if (!ins_pos_ok)
                    status_next = ST_RANGE;
            end
            FUNC_DELETE:
            begin
                if (found)
                    match_index_next = idx_w[MIDX_W-1:0];
                else
                    status_next = ST_NOT_FOUND;
            end
            FUNC_READ:
            begin
                if (rd_pos_ok)
                    read_value_next = cell_q[pos_w[IDX_W-1:0]];
                else
                    status_next = ST_RANGE;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Output valid holds while stalled and loads on every accepted beat.
    assign out_valid_next = take || (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            match_index_reg <= match_index_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign match_index = match_index_reg;
    assign entry_count = entry_count_reg;

    // Checks on the count and the result register.
    `AIDL_ASSERT_IMPL(a_count_max, 1'b1, count_reg <= FULL_V, "count exceeds depth")
    `AIDL_ASSERT_NEXT(a_take_valid, take, out_valid_reg, "accepted beat gave no result")
    `AIDL_ASSERT_NEXT(a_ins_count, op.ins_go, count_reg == $past(count_reg) + CNT_W'(1), "insert count")
    `AIDL_ASSERT_IMPL(a_full_status, take && (status_next == ST_FULL), is_full, "full status while not full")
    `AIDL_ASSERT_NEXT(a_idle_count, !take, count_reg == $past(count_reg), "count moved without a beat")

endmodule
